FILE: sv/drsk_pkg.sv
// Package for the dual-range scalar Kalman smoother.
// Holds fixed-point widths, register indexes, micro-ops and the microcode ROM.
// No dependencies.
package drsk_pkg;

  // Number formats
  localparam int FRAC_BITS   = 8;                  // fraction bits of a distance
  localparam int MM_W        = 16;                 // range reading, mm
  localparam int CONV_IN_W   = MM_W + FRAC_BITS;   // mm * 2^FRAC_BITS + 5
  localparam int CONV_W      = CONV_IN_W - 3;      // after /10
  localparam int RECIP_SHIFT = CONV_IN_W + 4;      // reciprocal exact for x < 2^(k-4)
  localparam int RECIP_W     = RECIP_SHIFT - 3;
  localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'((2 ** RECIP_SHIFT + 9) / 10);
  localparam int OFS_W       = 14;
  localparam int D_W         = CONV_W + 2;         // signed compensated distance
  localparam int DIST_W      = 13;
  localparam logic [D_W-1:0]    TEN_CM   = D_W'(10 << FRAC_BITS);
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam int GAIN_W      = 17;                 // Q0.16 plus the unity bit
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << 16);
  localparam int COV_W       = 32;
  localparam int PC_W        = COV_W + 1;
  localparam int DEN_W       = COV_W + 2;
  localparam int REM_W       = DEN_W + 1;
  localparam int CNT_W       = $clog2(GAIN_W);
  localparam int MUL_A_W     = CONV_IN_W;
  localparam int MUL_B_W     = RECIP_W;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int ACC_W       = 50;
  localparam int PC_LO_W     = 17;                 // covariance split for the multiplier
  localparam int ROUND_HALF  = 1 << 15;
  localparam int TDATA_O_W   = 48;                 // raw, gain, filtered padded to bytes
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_OFS  = 2'd0,
    REG_RIGHT_OFS = 2'd1,
    REG_PROC_VAR  = 2'd2,
    REG_SENS_VAR  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_ACCEPT,    // wait for and latch an input transfer
    OP_MUL_CONV,  // acc = (mm<<F + 5) * recip(10)
    OP_RAW_PC,    // raw distance, predicted covariance
    OP_DIV_INIT,  // load divider
    OP_DIV_STEP,  // one restoring-division step
    OP_GAIN,      // gain and its complement
    OP_MUL_PLO,   // acc = ng * pc[lo]
    OP_MUL_PHI,   // acc += ng * pc[hi] << 17
    OP_WR_P,      // covariance write-back
    OP_MUL_NX,    // acc = ng * X + half
    OP_MUL_GR,    // acc += g * raw
    OP_WR_X       // estimate write-back, result out
  } op_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_INPUT,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef enum logic [3:0] {
    ST_ACCEPT, ST_CONV, ST_RAW, ST_DIV_INIT, ST_DIV_STEP, ST_GAIN,
    ST_P_LO, ST_P_HI, ST_P_WR, ST_X_OLD, ST_X_RAW, ST_X_WR
  } step_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;    // jump to target when true
    step_e target;
    logic  wrap;    // fall through to the first step
  } ctrl_t;

  function automatic ctrl_t ucode_rom(step_e s);
    ctrl_t w;
    w = '{op: OP_ACCEPT, cond: COND_NO_INPUT, target: ST_ACCEPT, wrap: 1'b0};
    unique case (s)
      ST_ACCEPT:   w = '{OP_ACCEPT,   COND_NO_INPUT, ST_ACCEPT,   1'b0};
      ST_CONV:     w = '{OP_MUL_CONV, COND_NONE,     ST_ACCEPT,   1'b0};
      ST_RAW:      w = '{OP_RAW_PC,   COND_NONE,     ST_ACCEPT,   1'b0};
      ST_DIV_INIT: w = '{OP_DIV_INIT, COND_NONE,     ST_ACCEPT,   1'b0};
      ST_DIV_STEP: w = '{OP_DIV_STEP, COND_DIV_MORE, ST_DIV_STEP, 1'b0};
      ST_GAIN:     w = '{OP_GAIN,     COND_NONE,     ST_ACCEPT,   1'b0};
      ST_P_LO:     w = '{OP_MUL_PLO,  COND_NONE,     ST_ACCEPT,   1'b0};
      ST_P_HI:     w = '{OP_MUL_PHI,  COND_NONE,     ST_ACCEPT,   1'b0};
      ST_P_WR:     w = '{OP_WR_P,     COND_NONE,     ST_ACCEPT,   1'b0};
      ST_X_OLD:    w = '{OP_MUL_NX,   COND_NONE,     ST_ACCEPT,   1'b0};
      ST_X_RAW:    w = '{OP_MUL_GR,   COND_NONE,     ST_ACCEPT,   1'b0};
      ST_X_WR:     w = '{OP_WR_X,     COND_OUT_BUSY, ST_X_WR,     1'b1};
      default:     w = '{OP_ACCEPT,   COND_NO_INPUT, ST_ACCEPT,   1'b0};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/dual_range_scalar_kalman_top.sv
// Dual-range scalar Kalman smoother, top level.
// Microcoded sequencer over one multiplier, one accumulator and a restoring divider.
// Depends on drsk_pkg.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid_i/tready_o  tdata: range_mm[15:0]; tuser: channel
//  m_*       out  m_tvalid_o/tready_i  tdata: raw[12:0] gain[29:13] filtered[42:30]
//  cfg_*     in   cfg_valid_i/ready_o  cfg_index_i, cfg_data_i (always ready)
//
// An item runs from its input transfer until its result is loaded into the
// output register; the gain division (17 steps, one quotient bit per cycle)
// dominates. The next input transfer can be taken the cycle after that load.
// Reset (rst_ni, async, low) restores the default offsets and variances and
// zeroes both channels' covariance and estimate; no clearing pass is needed.
// A result waits in the output register while the next item is taken and
// worked on; the sequencer only holds at its final step if that register is
// still occupied.
module dual_range_scalar_kalman_top
  import drsk_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [MM_W-1:0]       s_tdata_i,   // [15:0] range_mm
  input  logic                  s_tuser_i,   // [0] channel
  // result stream
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [TDATA_O_W-1:0]  m_tdata_o,   // [12:0] raw_distance, [29:13] gain,
                                             // [42:30] filtered_distance, rest zero
  output logic                  m_tuser_o,   // [0] channel_out
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  logic signed [OFS_W-1:0] left_ofs_q, right_ofs_q;
  logic [COV_W-1:0]        proc_var_q, sens_var_q;

  // per-channel state (two entries, indexed by the channel bit)
  logic [COV_W-1:0]  cov_q [2];
  logic [DIST_W-1:0] est_q [2];

  // sequencer
  step_e seq_q, seq_d;
  ctrl_t ctrl;
  logic  jump;

  // datapath
  logic              chan_q;
  logic [MM_W-1:0]   mm_q;
  logic [ACC_W-1:0]  acc_q;
  logic [DIST_W-1:0] raw_q;
  logic [PC_W-1:0]   pc_q;
  logic [DEN_W-1:0]  den_q;
  logic              den_zero_q;
  logic [REM_W-1:0]  rem_q;
  logic [GAIN_W-1:0] quo_q;
  logic [GAIN_W-1:0] dbits_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [GAIN_W-1:0] g_q, ng_q;

  // output register
  logic              m_valid_q;
  logic              out_chan_q;
  logic [DIST_W-1:0] out_raw_q, out_filt_q;
  logic [GAIN_W-1:0] out_gain_q;

  logic in_fire, out_busy, out_load;
  assign in_fire  = s_tvalid_i && s_tready_o;
  assign out_busy = m_valid_q && !m_tready_i;

  assign ctrl       = ucode_rom(seq_q);
  assign s_tready_o = (ctrl.op == OP_ACCEPT);
  assign out_load   = (ctrl.op == OP_WR_X) && !out_busy;

  always_comb begin
    unique case (ctrl.cond)
      COND_NONE:     jump = 1'b0;
      COND_NO_INPUT: jump = !s_tvalid_i;
      COND_DIV_MORE: jump = (cnt_q != '0);
      COND_OUT_BUSY: jump = out_busy;
      default:       jump = 1'b0;
    endcase
    if (jump)           seq_d = ctrl.target;
    else if (ctrl.wrap) seq_d = ST_ACCEPT;
    else                seq_d = step_e'(seq_q + 4'd1);
  end

  // --- shared multiplier -------------------------------------------------
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    mul_a = MUL_A_W'(ng_q);
    mul_b = '0;
    case (ctrl.op)
      OP_MUL_CONV: begin
        mul_a = {mm_q, FRAC_BITS'(0)} + MUL_A_W'(5);   // round half up before /10
        mul_b = RECIP_TEN;
      end
      OP_MUL_PLO: mul_b = MUL_B_W'(pc_q[PC_LO_W-1:0]);
      OP_MUL_PHI: mul_b = MUL_B_W'(pc_q[PC_W-1:PC_LO_W]);
      OP_MUL_NX:  mul_b = MUL_B_W'(est_q[chan_q]);
      OP_MUL_GR: begin
        mul_a = MUL_A_W'(g_q);
        mul_b = MUL_B_W'(raw_q);
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  // --- distance compensation ---------------------------------------------
  logic [CONV_W-1:0]       conv;
  logic signed [OFS_W-1:0] ofs;
  logic signed [D_W-1:0]   comp_dist;
  logic [D_W-1:0]          mag;
  logic [DIST_W-1:0]       raw_d;

  assign conv      = acc_q[RECIP_SHIFT +: CONV_W];
  assign ofs       = chan_q ? right_ofs_q : left_ofs_q;
  assign comp_dist = $signed({2'b00, conv}) + $signed({{(D_W-OFS_W){ofs[OFS_W-1]}}, ofs});

  always_comb begin
    if (comp_dist > $signed(TEN_CM)) mag = TEN_CM;
    else if (comp_dist[D_W-1])       mag = D_W'(-comp_dist);   // mirror a negative reading
    else                             mag = D_W'(comp_dist);
    raw_d = (mag > D_W'(DIST_MAX)) ? DIST_MAX : mag[DIST_W-1:0];
  end

  // --- divider step ------------------------------------------------------
  logic [REM_W-1:0] trial;
  logic             fits;
  assign trial = {rem_q[REM_W-2:0], dbits_q[GAIN_W-1]};
  assign fits  = (trial >= REM_W'(den_q));

  // --- write-back values -------------------------------------------------
  logic [COV_W-1:0]  p_new;
  logic [DIST_W-1:0] x_new;
  logic [ACC_W-17:0] x_full;

  assign p_new  = (|acc_q[ACC_W-1:COV_W+16]) ? '1 : acc_q[COV_W+15:16];
  assign x_full = acc_q[ACC_W-1:16];
  assign x_new  = (x_full > (ACC_W-16)'(DIST_MAX)) ? DIST_MAX : x_full[DIST_W-1:0];

  // --- control state -----------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= ST_ACCEPT;
      m_valid_q   <= 1'b0;
      left_ofs_q  <= OFS_W'(-479);
      right_ofs_q <= OFS_W'(-410);
      proc_var_q  <= COV_W'(65536);
      sens_var_q  <= COV_W'(65536);
      cov_q[0]    <= '0;
      cov_q[1]    <= '0;
      est_q[0]    <= '0;
      est_q[1]    <= '0;
    end else begin
      seq_q <= seq_d;
      if (out_load)        m_valid_q <= 1'b1;
      else if (m_tready_i) m_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          REG_LEFT_OFS:  left_ofs_q  <= cfg_data_i[OFS_W-1:0];
          REG_RIGHT_OFS: right_ofs_q <= cfg_data_i[OFS_W-1:0];
          REG_PROC_VAR:  proc_var_q  <= cfg_data_i[COV_W-1:0];
          REG_SENS_VAR:  sens_var_q  <= cfg_data_i[COV_W-1:0];
          default: ;
        endcase
      end
      if (ctrl.op == OP_WR_P) cov_q[chan_q] <= p_new;
      if (out_load)           est_q[chan_q] <= x_new;
    end
  end

  assign cfg_ready_o = 1'b1;

  // --- datapath registers ------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (ctrl.op)
      OP_ACCEPT: if (in_fire) begin
        chan_q <= s_tuser_i;
        mm_q   <= s_tdata_i;
      end
      OP_MUL_CONV: acc_q <= ACC_W'(prod);
      OP_RAW_PC: begin
        raw_q <= raw_d;
        pc_q  <= PC_W'(cov_q[chan_q]) + PC_W'(proc_var_q);
      end
      OP_DIV_INIT: begin
        den_q      <= DEN_W'(pc_q) + DEN_W'(sens_var_q);
        den_zero_q <= (pc_q == '0) && (sens_var_q == '0);
        rem_q      <= REM_W'(pc_q[PC_W-1:1]);         // numerator is pc << 16
        dbits_q    <= {pc_q[0], (GAIN_W-1)'(0)};
        quo_q      <= '0;
        cnt_q      <= CNT_W'(GAIN_W - 1);
      end
      OP_DIV_STEP: begin
        rem_q   <= fits ? trial - REM_W'(den_q) : trial;
        quo_q   <= {quo_q[GAIN_W-2:0], fits};
        dbits_q <= {dbits_q[GAIN_W-2:0], 1'b0};
        cnt_q   <= cnt_q - CNT_W'(1);
      end
      OP_GAIN: begin
        if (den_zero_q) begin
          g_q  <= '0;
          ng_q <= GAIN_ONE;
        end else if (quo_q > GAIN_ONE) begin
          g_q  <= GAIN_ONE;
          ng_q <= '0;
        end else begin
          g_q  <= quo_q;
          ng_q <= GAIN_ONE - quo_q;
        end
      end
      OP_MUL_PLO: acc_q <= ACC_W'(prod);
      OP_MUL_PHI: acc_q <= acc_q + ACC_W'({prod, (PC_LO_W)'(0)});
      OP_MUL_NX:  acc_q <= ACC_W'(prod) + ACC_W'(ROUND_HALF);
      OP_MUL_GR:  acc_q <= acc_q + ACC_W'(prod);
      default: ;
    endcase
    if (out_load) begin
      out_chan_q <= chan_q;
      out_raw_q  <= raw_q;
      out_gain_q <= g_q;
      out_filt_q <= x_new;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tuser_o  = out_chan_q;
  assign m_tdata_o  = {(TDATA_O_W - 2*DIST_W - GAIN_W)'(0), out_filt_q, out_gain_q, out_raw_q};

endmodule
